@@ hw/rtl/iau_pkg.sv @@
// Shared types, operation codes and saturation helpers for the interval ALU.
package iau_pkg;

    localparam int W      = 32;          // endpoint width, Q16.16
    localparam int FRAC   = 16;          // fraction bits
    localparam int PW     = 2 * W - FRAC; // scaled product width
    localparam int TOL_W  = 16;          // tolerance register width

    typedef logic signed [W-1:0]  word_t;
    typedef logic signed [PW-1:0] pword_t;
    typedef logic signed [W:0]    sum_t;

    typedef enum logic [3:0] {
        K_ADD      = 4'd0,
        K_SUB      = 4'd1,
        K_ADDC     = 4'd2,
        K_SCALE    = 4'd3,
        K_MULT     = 4'd4,
        K_SQUARE   = 4'd5,
        K_SQRT     = 4'd6,
        K_JOIN     = 4'd7,
        K_ISECT    = 4'd8,
        K_NARROW   = 4'd9,
        K_REDUCE   = 4'd10,
        K_SORT     = 4'd11,
        K_EQUAL    = 4'd12,
        K_CONTAINS = 4'd13,
        K_CLAMP    = 4'd14
    } kind_t;

    typedef struct packed {
        word_t v;
        logic  ov;
    } sat_t;

    typedef struct packed {
        word_t lo;
        word_t hi;
        logic  ov;
        logic  fl;
    } res_t;

    localparam word_t WORD_MAX = {1'b0, {(W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(W-1){1'b0}}};
    localparam word_t EMPTY_LO = word_t'(1) << FRAC;
    localparam word_t EMPTY_HI = -EMPTY_LO;

    function automatic sat_t sat_sum(input sum_t s);
        sat_t r;
        r.ov = (s[W] != s[W-1]);
        r.v  = r.ov ? (s[W] ? WORD_MIN : WORD_MAX) : s[W-1:0];
        return r;
    endfunction

    function automatic sat_t sat_wide(input pword_t x);
        sat_t r;
        r.ov = !((&x[PW-1:W-1]) || !(|x[PW-1:W-1]));
        r.v  = r.ov ? (x[PW-1] ? WORD_MIN : WORD_MAX) : x[W-1:0];
        return r;
    endfunction

endpackage

@@ hw/rtl/iau_sqrt.sv @@
// Pipelined digit-by-digit square root of a clamped Q16.16 endpoint.
module iau_sqrt
    import iau_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  word_t x,
    output word_t root
);

    localparam int RW     = W / 2 + FRAC / 2;  // root bits
    localparam int NW     = W + FRAC;          // radicand bits
    localparam int RMW    = RW + 3;            // partial remainder bits
    localparam int STAGES = 4;
    localparam int STEPS  = RW / STAGES;

    typedef struct packed {
        logic [NW-1:0]  n;
        logic [RMW-1:0] rem;
        logic [RW-1:0]  rt;
    } sq_t;

    function automatic sq_t sq_stage(input sq_t s);
        sq_t            r;
        logic [RMW-1:0] trial;
        r = s;
        for (int i = 0; i < STEPS; i++)
        begin
            r.rem = {r.rem[RMW-3:0], r.n[NW-1:NW-2]};
            r.n   = r.n << 2;
            trial = RMW'({r.rt, 2'b01});
            if (r.rem >= trial)
            begin
                r.rem = r.rem - trial;
                r.rt  = {r.rt[RW-2:0], 1'b1};
            end
            else
            begin
                r.rt = {r.rt[RW-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    sq_t init;
    sq_t st_reg  [STAGES];
    sq_t st_next [STAGES];

    always_comb
    begin
        init.n   = x[W-1] ? '0 : {x[W-2:0], {(FRAC+1){1'b0}}} >> 1;
        init.rem = '0;
        init.rt  = '0;
    end

    genvar g;
    generate
        for (g = 0; g < STAGES; g++)
        begin : g_stage
            if (g == 0)
            begin : g_first
                assign st_next[g] = sq_stage(init);
            end
            else
            begin : g_rest
                assign st_next[g] = sq_stage(st_reg[g-1]);
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    st_reg[g] <= st_next[g];
                end
            end
        end
    endgenerate

    assign root = word_t'(st_reg[STAGES-1].rt);

endmodule

@@ hw/rtl/iau_prod.sv @@
// Product lanes for scale, mult and square: multiply, min/max, saturate.
module iau_prod
    import iau_pkg::*;
(
    input  logic       clk,
    input  logic       en,
    input  logic [3:0] kind,
    input  word_t      a_lo,
    input  word_t      a_hi,
    input  word_t      b_lo,
    input  word_t      b_hi,
    input  word_t      scalar,
    output res_t       res
);

    pword_t     p_reg [4];
    pword_t     p_next [4];
    logic [3:0] k1_reg, k2_reg, k3_reg;
    logic       neg1_reg;
    logic       str1_reg, str2_reg, str3_reg;
    pword_t     lo2_reg, hi2_reg, bmin2_reg, bmax2_reg;
    pword_t     lo2_next, hi2_next;
    pword_t     lo3_reg, hi3_reg, lo3_next, hi3_next;
    res_t       res_reg, res_next;

    always_comb
    begin
        logic signed [2*W-1:0] pr0, pr1, pr2, pr3;
        word_t                 m0a, m0b, m1a, m1b;
        m0a = (kind == K_SCALE) ? scalar : a_lo;
        m0b = (kind == K_MULT)  ? b_lo   : a_lo;
        m1a = (kind == K_SCALE) ? scalar : a_hi;
        m1b = (kind == K_MULT)  ? b_hi   : a_hi;
        pr0 = (2*W)'(m0a) * (2*W)'(m0b);
        pr1 = (2*W)'(m1a) * (2*W)'(m1b);
        pr2 = (2*W)'(a_lo) * (2*W)'(b_hi);
        pr3 = (2*W)'(a_hi) * (2*W)'(b_lo);
        p_next[0] = pr0[2*W-1:FRAC];
        p_next[1] = pr1[2*W-1:FRAC];
        p_next[2] = pr2[2*W-1:FRAC];
        p_next[3] = pr3[2*W-1:FRAC];
    end

    // scale keeps its order, flipped for a negative scalar
    always_comb
    begin
        if (k1_reg == K_SCALE)
        begin
            lo2_next = neg1_reg ? p_reg[1] : p_reg[0];
            hi2_next = neg1_reg ? p_reg[0] : p_reg[1];
        end
        else
        begin
            lo2_next = (p_reg[1] < p_reg[0]) ? p_reg[1] : p_reg[0];
            hi2_next = (p_reg[0] < p_reg[1]) ? p_reg[1] : p_reg[0];
        end
    end

    always_comb
    begin
        lo3_next = lo2_reg;
        hi3_next = hi2_reg;
        if (k2_reg == K_MULT)
        begin
            lo3_next = (bmin2_reg < lo2_reg) ? bmin2_reg : lo2_reg;
            hi3_next = (hi2_reg < bmax2_reg) ? bmax2_reg : hi2_reg;
        end
    end

    always_comb
    begin
        sat_t sl, sh;
        sl = sat_wide(lo3_reg);
        sh = sat_wide(hi3_reg);
        res_next.hi = sh.v;
        res_next.fl = 1'b0;
        if (k3_reg == K_SQUARE && str3_reg)
        begin
            res_next.lo = '0;
            res_next.ov = sh.ov;
        end
        else
        begin
            res_next.lo = sl.v;
            res_next.ov = sl.ov | sh.ov;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg     <= p_next;
            k1_reg    <= kind;
            neg1_reg  <= scalar[W-1];
            str1_reg  <= ((a_lo < 0) && (a_hi > 0)) || ((a_lo > 0) && (a_hi < 0));
            lo2_reg   <= lo2_next;
            hi2_reg   <= hi2_next;
            bmin2_reg <= (p_reg[3] < p_reg[2]) ? p_reg[3] : p_reg[2];
            bmax2_reg <= (p_reg[2] < p_reg[3]) ? p_reg[3] : p_reg[2];
            k2_reg    <= k1_reg;
            str2_reg  <= str1_reg;
            lo3_reg   <= lo3_next;
            hi3_reg   <= hi3_next;
            k3_reg    <= k2_reg;
            str3_reg  <= str2_reg;
            res_reg   <= res_next;
        end
    end

    assign res = res_reg;

endmodule

@@ hw/rtl/interval_arithmetic_unit.sv @@
// Interval ALU on signed Q16.16 endpoints, seven register stages deep.
// Throughput: one item per cycle; the whole pipeline holds while the output stalls.
// The 32x32 multiplier lanes and the 4-stage square root pipeline set the depth.
// Reset (rst_n low, asynchronous) clears valid bits and both tolerance registers.
module interval_arithmetic_unit
    import iau_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,   // a_lo, a_hi, b_lo, b_hi, scalar
    input  logic [3:0]   s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // res_lo, res_hi, is_empty, flag, overflow, 5 pad
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_wdata
);

    localparam logic REG_ABS_TOL = 1'b0;
    localparam logic REG_REL_TOL = 1'b1;

    logic [TOL_W-1:0] abs_tol_reg, rel_tol_reg;
    logic [6:0]       v_reg;
    logic             en;

    // stage 0: input
    logic [3:0] k0_reg;
    word_t      al0_reg, ah0_reg, bl0_reg, bh0_reg, sc0_reg;

    // stage 1: sums, compares, distances
    logic [3:0]  k1_reg;
    word_t       al1_reg, ah1_reg, bl1_reg, bh1_reg, sc1_reg;
    sum_t        sl1_reg, sh1_reg, sl1_next, sh1_next;
    logic        c_ah_al1_reg, c_bh_bl1_reg, c_bl_al1_reg, c_ah_bh1_reg, c_sc_al1_reg;
    logic        cont1_reg;
    logic [W-1:0] dl1_reg, dh1_reg, ml1_reg, mh1_reg;
    logic [W-1:0] dl1_next, dh1_next, ml1_next, mh1_next;

    // stage 2: selection
    logic [3:0]        k2_reg;
    res_t              r2_reg, r2_next;
    logic [W+TOL_W-1:0] rl2_reg, rh2_reg, ll2_reg, lh2_reg;

    // stage 3..6
    logic [3:0] k3_reg, k4_reg;
    res_t       r3_reg, r3_next, r4_reg, r5_reg, r5_next, r6_reg;
    logic       emp6_reg;
    res_t       prod_res;
    word_t      sq_lo, sq_hi;

    assign en       = !v_reg[6] || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abs_tol_reg <= '0;
            rel_tol_reg <= '0;
            v_reg       <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_ABS_TOL)
            begin
                abs_tol_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == REG_REL_TOL)
            begin
                rel_tol_reg <= cfg_wdata;
            end
            if (en)
            begin
                v_reg <= {v_reg[5:0], s_tvalid};
            end
        end
    end

    iau_prod u_prod (
        .clk    (clk),
        .en     (en),
        .kind   (k0_reg),
        .a_lo   (al0_reg),
        .a_hi   (ah0_reg),
        .b_lo   (bl0_reg),
        .b_hi   (bh0_reg),
        .scalar (sc0_reg),
        .res    (prod_res)
    );

    iau_sqrt u_sqrt_lo (
        .clk  (clk),
        .en   (en),
        .x    (al0_reg),
        .root (sq_lo)
    );

    iau_sqrt u_sqrt_hi (
        .clk  (clk),
        .en   (en),
        .x    (ah0_reg),
        .root (sq_hi)
    );

    // stage 1
    always_comb
    begin
        word_t       opb_lo, opb_hi;
        sum_t        d_l, d_h;
        logic [W-1:0] ua, ub, uc, ud;
        opb_lo = (k0_reg == K_ADDC) ? sc0_reg : bl0_reg;
        opb_hi = (k0_reg == K_ADDC) ? sc0_reg : bh0_reg;
        if (k0_reg == K_SUB)
        begin
            sl1_next = sum_t'(al0_reg) - sum_t'(opb_lo);
            sh1_next = sum_t'(ah0_reg) - sum_t'(opb_hi);
        end
        else
        begin
            sl1_next = sum_t'(al0_reg) + sum_t'(opb_lo);
            sh1_next = sum_t'(ah0_reg) + sum_t'(opb_hi);
        end
        d_l      = sum_t'(al0_reg) - sum_t'(bl0_reg);
        d_h      = sum_t'(ah0_reg) - sum_t'(bh0_reg);
        dl1_next = d_l[W] ? W'(-d_l) : d_l[W-1:0];
        dh1_next = d_h[W] ? W'(-d_h) : d_h[W-1:0];
        ua       = al0_reg[W-1] ? (~al0_reg + 1'b1) : al0_reg;
        ub       = bl0_reg[W-1] ? (~bl0_reg + 1'b1) : bl0_reg;
        uc       = ah0_reg[W-1] ? (~ah0_reg + 1'b1) : ah0_reg;
        ud       = bh0_reg[W-1] ? (~bh0_reg + 1'b1) : bh0_reg;
        ml1_next = (ua > ub) ? ua : ub;
        mh1_next = (uc > ud) ? uc : ud;
    end

    // stage 2
    always_comb
    begin
        sat_t         s_l, s_h;
        logic [W-1:0] tol;
        logic         dl_lt, dl_gt, dh_lt, dh_gt;
        tol   = W'(abs_tol_reg);
        dl_lt = dl1_reg < tol;
        dl_gt = dl1_reg > tol;
        dh_lt = dh1_reg < tol;
        dh_gt = dh1_reg > tol;
        s_l   = sat_sum(sl1_reg);
        s_h   = sat_sum(sh1_reg);
        r2_next = '0;
        unique case (k1_reg)
            K_ADD, K_SUB, K_ADDC:
            begin
                r2_next.lo = s_l.v;
                r2_next.hi = s_h.v;
                r2_next.ov = s_l.ov | s_h.ov;
            end
            K_JOIN:
            begin
                if (c_ah_al1_reg)
                begin
                    r2_next.lo = bl1_reg;
                    r2_next.hi = bh1_reg;
                end
                else if (c_bh_bl1_reg)
                begin
                    r2_next.lo = al1_reg;
                    r2_next.hi = ah1_reg;
                end
                else
                begin
                    r2_next.lo = c_bl_al1_reg ? bl1_reg : al1_reg;
                    r2_next.hi = c_ah_bh1_reg ? bh1_reg : ah1_reg;
                end
            end
            K_ISECT:
            begin
                r2_next.lo = dl_lt ? (c_bl_al1_reg ? bl1_reg : al1_reg)
                                   : (c_bl_al1_reg ? al1_reg : bl1_reg);
                r2_next.hi = dh_lt ? (c_ah_bh1_reg ? bh1_reg : ah1_reg)
                                   : (c_ah_bh1_reg ? ah1_reg : bh1_reg);
            end
            K_NARROW:
            begin
                r2_next.lo = (!c_bl_al1_reg && dl_gt) ? bl1_reg : al1_reg;
                r2_next.hi = (!c_ah_bh1_reg && dh_gt) ? bh1_reg : ah1_reg;
            end
            K_REDUCE:
            begin
                r2_next.lo = (c_bl_al1_reg && dl_gt) ? al1_reg : bl1_reg;
                r2_next.hi = (c_ah_bh1_reg && dh_gt) ? ah1_reg : bh1_reg;
            end
            K_SORT:
            begin
                r2_next.lo = c_ah_al1_reg ? ah1_reg : al1_reg;
                r2_next.hi = c_ah_al1_reg ? al1_reg : ah1_reg;
            end
            K_CONTAINS:
            begin
                r2_next.fl = cont1_reg;
            end
            K_CLAMP:
            begin
                // second half of the clamp follows in the next stage
                r2_next.lo = c_sc_al1_reg ? al1_reg : sc1_reg;
                r2_next.hi = ah1_reg;
            end
            default:
            begin
                r2_next = '0;
            end
        endcase
    end

    // stage 3
    always_comb
    begin
        r3_next = r2_reg;
        unique case (k2_reg)
            K_ISECT:
            begin
                if (r2_reg.hi < r2_reg.lo)
                begin
                    r3_next.lo = EMPTY_LO;
                    r3_next.hi = EMPTY_HI;
                end
            end
            K_CLAMP:
            begin
                r3_next.lo = (r2_reg.hi < r2_reg.lo) ? r2_reg.hi : r2_reg.lo;
                r3_next.hi = r3_next.lo;
            end
            K_EQUAL:
            begin
                r3_next.fl = (rl2_reg >= ll2_reg) && (rh2_reg >= lh2_reg);
            end
            default:
            begin
                r3_next = r2_reg;
            end
        endcase
    end

    // stage 5: merge product and root lanes
    always_comb
    begin
        r5_next = r4_reg;
        if (k4_reg == K_SCALE || k4_reg == K_MULT || k4_reg == K_SQUARE)
        begin
            r5_next = prod_res;
        end
        else if (k4_reg == K_SQRT)
        begin
            r5_next.lo = sq_lo;
            r5_next.hi = sq_hi;
            r5_next.ov = 1'b0;
            r5_next.fl = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k0_reg  <= s_tuser;
            al0_reg <= s_tdata[31:0];
            ah0_reg <= s_tdata[63:32];
            bl0_reg <= s_tdata[95:64];
            bh0_reg <= s_tdata[127:96];
            sc0_reg <= s_tdata[159:128];

            k1_reg       <= k0_reg;
            al1_reg      <= al0_reg;
            ah1_reg      <= ah0_reg;
            bl1_reg      <= bl0_reg;
            bh1_reg      <= bh0_reg;
            sc1_reg      <= sc0_reg;
            sl1_reg      <= sl1_next;
            sh1_reg      <= sh1_next;
            c_ah_al1_reg <= ah0_reg < al0_reg;
            c_bh_bl1_reg <= bh0_reg < bl0_reg;
            c_bl_al1_reg <= bl0_reg < al0_reg;
            c_ah_bh1_reg <= ah0_reg < bh0_reg;
            c_sc_al1_reg <= sc0_reg < al0_reg;
            cont1_reg    <= !(bl0_reg < al0_reg) && !(ah0_reg < bl0_reg)
                         && !(bh0_reg < al0_reg) && !(ah0_reg < bh0_reg);
            dl1_reg      <= dl1_next;
            dh1_reg      <= dh1_next;
            ml1_reg      <= ml1_next;
            mh1_reg      <= mh1_next;

            k2_reg  <= k1_reg;
            r2_reg  <= r2_next;
            rl2_reg <= (W+TOL_W)'(ml1_reg) * (W+TOL_W)'(rel_tol_reg);
            rh2_reg <= (W+TOL_W)'(mh1_reg) * (W+TOL_W)'(rel_tol_reg);
            ll2_reg <= {dl1_reg, {TOL_W{1'b0}}};
            lh2_reg <= {dh1_reg, {TOL_W{1'b0}}};

            k3_reg   <= k2_reg;
            r3_reg   <= r3_next;
            k4_reg   <= k3_reg;
            r4_reg   <= r3_reg;
            r5_reg   <= r5_next;
            r6_reg   <= r5_reg;
            emp6_reg <= r5_reg.hi < r5_reg.lo;
        end
    end

    assign m_tvalid = v_reg[6];
    assign m_tdata  = {5'b0, r6_reg.ov, r6_reg.fl, emp6_reg, r6_reg.hi, r6_reg.lo};

endmodule

@@ tb/sv/tb_interval_arithmetic_unit.sv @@
// Self-checking testbench for the interval ALU: directed and random intervals against a predictor.
module tb_interval_arithmetic_unit
    import iau_pkg::*;
();

    localparam int LATENCY = 7;
    localparam int STALL_LIMIT = 5000;
    localparam int N_RANDOM = 1830;

    typedef struct {
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic               empty;
        logic               fl;
        logic               ov;
    } interval_res_t;

    // abs_tolerance and rel_tolerance as seen by the predictor
    logic [15:0] abs_tol_q;
    logic [15:0] rel_tol_q;

    function automatic logic signed [31:0] clip(input logic signed [127:0] x, inout logic ov);
        if (x < -128'sd2147483648)
        begin
            ov = 1'b1;
            return 32'sh80000000;
        end
        if (x > 128'sd2147483647)
        begin
            ov = 1'b1;
            return 32'sh7fffffff;
        end
        return x[31:0];
    endfunction

    // Q16.16 product, floor rounding (arithmetic shift)
    function automatic logic signed [127:0] qmul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [127:0] p;
        p = 128'(a) * 128'(b);
        return p >>> 16;
    endfunction

    function automatic logic signed [31:0] qsqrt(input logic signed [31:0] x, inout logic ov);
        logic [127:0] n;
        logic [127:0] root;
        logic [127:0] t;
        if (x <= 0)
            return 0;
        n = 128'(x) << 16;
        root = 0;
        for (int b = 63; b >= 0; b--)
        begin
            t = root | (128'd1 << b);
            if (t * t <= n)
                root = t;
        end
        return clip($signed(root), ov);
    endfunction

    function automatic logic [32:0] mag(input logic signed [31:0] x);
        return x < 0 ? 33'(-34'(x)) : 33'(x);
    endfunction

    function automatic logic close_rel(input logic signed [31:0] x, input logic signed [31:0] y);
        logic [63:0] diff;
        logic [63:0] m;
        diff = (x < y) ? 64'(35'(y) - 35'(x)) : 64'(35'(x) - 35'(y));
        m = (mag(x) > mag(y)) ? 64'(mag(x)) : 64'(mag(y));
        return (128'(diff) * 65536) <= (128'(m) * rel_tol_q);
    endfunction

    function automatic logic [32:0] gap(input logic signed [31:0] x, input logic signed [31:0] y);
        return (x < y) ? 33'(34'(y) - 34'(x)) : 33'(34'(x) - 34'(y));
    endfunction

    function automatic interval_res_t predict_interval(input logic [3:0] k,
        input logic signed [31:0] al, input logic signed [31:0] ah,
        input logic signed [31:0] bl, input logic signed [31:0] bh,
        input logic signed [31:0] s);
        interval_res_t r;
        logic signed [127:0] p[4];
        logic signed [127:0] mn;
        logic signed [127:0] mx;
        logic ov;
        logic [32:0] tol;
        ov = 0;
        tol = 33'(abs_tol_q);
        r.lo = 0;
        r.hi = 0;
        r.fl = 0;
        case (k)
            K_ADD:
            begin
                r.lo = clip(128'(al) + 128'(bl), ov);
                r.hi = clip(128'(ah) + 128'(bh), ov);
            end
            K_SUB:
            begin
                r.lo = clip(128'(al) - 128'(bl), ov);
                r.hi = clip(128'(ah) - 128'(bh), ov);
            end
            K_ADDC:
            begin
                r.lo = clip(128'(al) + 128'(s), ov);
                r.hi = clip(128'(ah) + 128'(s), ov);
            end
            K_SCALE:
            begin
                if (s >= 0)
                begin
                    r.lo = clip(qmul(s, al), ov);
                    r.hi = clip(qmul(s, ah), ov);
                end
                else
                begin
                    r.lo = clip(qmul(s, ah), ov);
                    r.hi = clip(qmul(s, al), ov);
                end
            end
            K_MULT:
            begin
                p[0] = qmul(al, bl);
                p[1] = qmul(ah, bh);
                p[2] = qmul(al, bh);
                p[3] = qmul(ah, bl);
                mn = p[0];
                mx = p[0];
                for (int i = 1; i < 4; i++)
                begin
                    if (p[i] < mn) mn = p[i];
                    if (p[i] > mx) mx = p[i];
                end
                r.lo = clip(mn, ov);
                r.hi = clip(mx, ov);
            end
            K_SQUARE:
            begin
                p[0] = qmul(al, al);
                p[1] = qmul(ah, ah);
                mn = (p[1] < p[0]) ? p[1] : p[0];
                mx = (p[0] < p[1]) ? p[1] : p[0];
                r.lo = ((al < 0 && ah > 0) || (al > 0 && ah < 0)) ? 32'sd0 : clip(mn, ov);
                r.hi = clip(mx, ov);
            end
            K_SQRT:
            begin
                r.lo = qsqrt(al, ov);
                r.hi = qsqrt(ah, ov);
            end
            K_JOIN:
            begin
                if (ah < al)
                begin
                    r.lo = bl;
                    r.hi = bh;
                end
                else if (bh < bl)
                begin
                    r.lo = al;
                    r.hi = ah;
                end
                else
                begin
                    r.lo = (bl < al) ? bl : al;
                    r.hi = (ah < bh) ? bh : ah;
                end
            end
            K_ISECT:
            begin
                if (gap(al, bl) < tol) r.lo = (bl < al) ? bl : al;
                else r.lo = (al < bl) ? bl : al;
                if (gap(ah, bh) < tol) r.hi = (ah < bh) ? bh : ah;
                else r.hi = (bh < ah) ? bh : ah;
                if (r.hi < r.lo)
                begin
                    r.lo = EMPTY_LO;
                    r.hi = EMPTY_HI;
                end
            end
            K_NARROW:
            begin
                r.lo = (al < bl && gap(al, bl) > tol) ? bl : al;
                r.hi = (bh < ah && gap(ah, bh) > tol) ? bh : ah;
            end
            K_REDUCE:
            begin
                r.lo = (bl < al && gap(al, bl) > tol) ? al : bl;
                r.hi = (ah < bh && gap(ah, bh) > tol) ? ah : bh;
            end
            K_SORT:
            begin
                r.lo = (ah < al) ? ah : al;
                r.hi = (ah < al) ? al : ah;
            end
            K_EQUAL:
                r.fl = close_rel(al, bl) && close_rel(ah, bh);
            K_CONTAINS:
                r.fl = !(bl < al) && !(ah < bl) && !(bh < al) && !(ah < bh);
            K_CLAMP:
            begin
                r.lo = (s < al) ? al : s;
                if (ah < r.lo) r.lo = ah;
                r.hi = r.lo;
            end
            default: ;
        endcase
        r.empty = r.hi < r.lo;
        r.ov = ov;
        return r;
    endfunction

    class interval_scoreboard;
        interval_res_t pending[$];
        int mismatches = 0;
        int checked = 0;

        function void note_input(input logic [3:0] k, input logic [159:0] d);
            pending.insert(pending.size(), predict_interval(k, d[31:0], d[63:32], d[95:64],
                                                            d[127:96], d[159:128]));
        endfunction

        function void check_result(input logic [71:0] d);
            interval_res_t e;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %h", d);
                return;
            end
            e = pending.pop_front();
            if (d[31:0] !== e.lo || d[63:32] !== e.hi || d[64] !== e.empty ||
                d[65] !== e.fl || d[66] !== e.ov)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d exp lo=%h hi=%h e=%b f=%b o=%b got lo=%h hi=%h e=%b f=%b o=%b",
                             checked, e.lo, e.hi, e.empty, e.fl, e.ov,
                             d[31:0], d[63:32], d[64], d[65], d[66]);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [159:0] s_tdata = '0;
    logic [3:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [71:0] m_tdata;
    logic cfg_we = 0;
    logic cfg_index = 0;
    logic [15:0] cfg_wdata = '0;

    interval_scoreboard board;
    logic src_idle_ok = 1;
    logic sink_idle_ok = 1;
    logic hold_sink = 0;
    int idle_cycles = 0;
    int n_sent = 0;

    interval_arithmetic_unit uut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            board.note_input(s_tuser, s_tdata);
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("ERROR: watchdog expired");
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: random stall bursts, a long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_sink)
                m_tready <= 0;
            else if (sink_idle_ok && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
                m_tready <= 1;
            end
            else
                m_tready <= 1;
        end
    end

    task automatic send_item(input logic [3:0] k, input logic [31:0] al, input logic [31:0] ah,
                             input logic [31:0] bl, input logic [31:0] bh, input logic [31:0] s);
        if (src_idle_ok && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= k;
        s_tdata <= {s, bh, bl, ah, al};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        n_sent++;
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] v);
        s_tvalid <= 0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 0;
        if (idx) rel_tol_q = v; else abs_tol_q = v;
    endtask

    function automatic logic [31:0] rnd_end();
        case ($urandom_range(0, 5))
            0: return 32'h80000000 + $urandom_range(0, 3);
            1: return 32'h7fffffff - $urandom_range(0, 3);
            2: return $urandom_range(0, 8) << 14;
            3: return -($urandom_range(0, 8) << 14);
            4: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random();
        logic [31:0] al;
        logic [31:0] ah;
        logic [31:0] bl;
        logic [31:0] bh;
        logic [3:0] k;
        al = rnd_end();
        ah = rnd_end();
        bl = rnd_end();
        bh = rnd_end();
        k = 4'($urandom_range(0, 15));
        // mostly proper intervals, sometimes B close to A to hit tolerance paths
        if ($urandom_range(0, 3) != 0 && $signed(ah) < $signed(al))
            {al, ah} = {ah, al};
        if ($urandom_range(0, 3) == 0)
        begin
            bl = al + $urandom_range(0, 300) - 150;
            bh = ah + $urandom_range(0, 300) - 150;
        end
        else if ($urandom_range(0, 3) != 0 && $signed(bh) < $signed(bl))
            {bl, bh} = {bh, bl};
        send_item(k, al, ah, bl, bh, rnd_end());
    endtask

    initial
    begin
        logic [15:0] abs_set[4];
        logic [15:0] rel_set[4];
        board = new();
        abs_tol_q = 0;
        rel_tol_q = 0;
        abs_set = '{16'd0, 16'hffff, 16'd100, 16'd1};
        rel_set = '{16'd0, 16'hffff, 16'd655, 16'd1};
        repeat (11) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        send_item(K_ADD, 32'h7fffffff, 32'h80000000, 32'd1, 32'hffffffff, 0);
        send_item(K_SUB, 32'h80000000, 32'h7fffffff, 32'd1, 32'hffffffff, 0);
        send_item(K_ADDC, 32'h10000, 32'h20000, 0, 0, 32'h7fffffff);
        send_item(K_SCALE, 32'hffff0000, 32'h20000, 0, 0, 32'hfffe0000);
        send_item(K_SCALE, 32'h7fffffff, 32'h80000000, 0, 0, 32'h7fffffff);
        send_item(K_MULT, 32'hfffe0000, 32'h30000, 32'hffff8000, 32'h10000, 0);
        send_item(K_MULT, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 0);
        send_item(K_SQUARE, 32'hfffe0000, 32'h30000, 0, 0, 0);
        send_item(K_SQUARE, 32'h30000, 32'hfffe0000, 0, 0, 0);
        send_item(K_SQUARE, 32'hffffffff, 32'hffffffff, 0, 0, 0);
        send_item(K_SQRT, 32'hffff0000, 32'h7fffffff, 0, 0, 0);
        send_item(K_SQRT, 32'h20000, 32'd1, 0, 0, 0);
        send_item(K_JOIN, 32'h10000, 32'hffff0000, 32'd5, 32'd9, 0);
        send_item(K_JOIN, 32'd5, 32'd9, 32'h10000, 32'hffff0000, 0);
        send_item(K_JOIN, 32'd5, 32'd9, 32'd1, 32'd20, 0);
        send_item(K_ISECT, 32'd0, 32'd10, 32'd20, 32'd30, 0);
        send_item(K_ISECT, 32'd0, 32'd100, 32'd50, 32'd200, 0);
        send_item(K_NARROW, 32'd0, 32'd100, 32'd10, 32'd90, 0);
        send_item(K_REDUCE, 32'd10, 32'd90, 32'd0, 32'd100, 0);
        send_item(K_SORT, 32'd9, 32'hfffffff0, 0, 0, 0);
        send_item(K_EQUAL, 32'h10000, 32'h20000, 32'h10000, 32'h20000, 0);
        send_item(K_CONTAINS, 32'h80000000, 32'h7fffffff, 32'd0, 32'd1, 0);
        send_item(K_CLAMP, 32'd0, 32'd100, 0, 0, 32'h7fffffff);
        send_item(K_CLAMP, 32'd100, 32'd0, 0, 0, 32'h80000000);
        send_item(4'd15, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);

        // fill the pipeline while the receiver holds off
        hold_sink = 1;
        fork
            begin
                repeat (200) @(negedge clk);
                hold_sink = 0;
            end
            for (int i = 0; i < 30; i++) send_random();
        join

        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(1'b0, abs_set[ph]);
            write_reg(1'b1, rel_set[ph]);
            if (ph == 3)
            begin
                src_idle_ok = 0;
                sink_idle_ok = 0;
            end
            for (int i = 0; i < N_RANDOM / 4; i++) send_random();
        end
        s_tvalid <= 0;

        while (board.pending.size() != 0) @(negedge clk);
        repeat (LATENCY * 3) @(negedge clk);
        $display("Run covered %0d items of all 16 kind codes over 4 tolerance settings.", n_sent);
        $display("%0d results checked, %0d mismatches.", board.checked, board.mismatches);
        if (board.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

@@ sim.f @@
hw/rtl/iau_pkg.sv
hw/rtl/iau_sqrt.sv
hw/rtl/iau_prod.sv
hw/rtl/interval_arithmetic_unit.sv
tb/sv/tb_interval_arithmetic_unit.sv
